>>> hdl/cvsd_pkg.sv
// Shared types and constants of the CAN vehicle signal decoder.
`default_nettype none

package cvsd_pkg;

    localparam int IdWidth     = 29;
    localparam int NumIds      = 7;
    localparam int ValueWidth  = 24;
    localparam int RegAddrBits = 3;

    localparam logic [31:0] TimeoutReset = 32'd500000;

    // Division by 25 and by 5 through scaled reciprocals (exact over the operand ranges).
    localparam logic [23:0] WheelRecip = 24'd10737419;
    localparam int          WheelShift = 28;
    localparam logic [22:0] SteerRecip = 23'd6710887;
    localparam int          SteerShift = 25;

    typedef enum logic [3:0] {
        KIND_NONE     = 4'd0,
        KIND_RPM      = 4'd1,
        KIND_THROTTLE = 4'd2,
        KIND_TEMPS    = 4'd3,
        KIND_FRONT    = 4'd4,
        KIND_REAR     = 4'd5,
        KIND_STEERING = 4'd6,
        KIND_BRAKE    = 4'd7,
        KIND_TICK     = 4'd8
    } t_kind;

    typedef enum logic [RegAddrBits-1:0] {
        REG_RPM_ID      = 3'd0,
        REG_THROTTLE_ID = 3'd1,
        REG_TEMP_ID     = 3'd2,
        REG_FRONT_ID    = 3'd3,
        REG_REAR_ID     = 3'd4,
        REG_STEERING_ID = 3'd5,
        REG_BRAKE_ID    = 3'd6,
        REG_TIMEOUT     = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [NumIds-1:0][IdWidth-1:0] ids;
        logic [31:0]                    timeout_us;
    } t_cfg;

    typedef struct packed {
        t_kind                         kind;
        logic signed [ValueWidth-1:0]  value_a;
        logic signed [ValueWidth-1:0]  value_b;
    } t_decoded;

endpackage

`default_nettype wire

>>> hdl/cvsd_regs.sv
// Configuration register file with an APB-style access port.
`default_nettype none

module cvsd_regs (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [4:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready,
    output cvsd_pkg::t_cfg            o_cfg
);

    logic [cvsd_pkg::NumIds-1:0][cvsd_pkg::IdWidth-1:0] r_ids;
    logic [31:0]                                        r_timeout;
    cvsd_pkg::t_reg_idx                                 idx;
    logic                                               wr_en;

    assign pready = 1'b1;
    assign idx    = cvsd_pkg::t_reg_idx'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ids     <= '0;
            r_timeout <= cvsd_pkg::TimeoutReset;
        end else if (wr_en) begin
            if (idx == cvsd_pkg::REG_TIMEOUT) begin
                r_timeout <= pwdata;
            end else begin
                r_ids[idx] <= pwdata[cvsd_pkg::IdWidth-1:0];
            end
        end
    end

    always_comb begin
        unique case (idx)
            cvsd_pkg::REG_TIMEOUT: prdata = r_timeout;
            default:               prdata = {3'd0, r_ids[idx]};
        endcase
    end

    assign o_cfg.ids        = r_ids;
    assign o_cfg.timeout_us = r_timeout;

endmodule

`default_nettype wire

>>> hdl/cvsd_decode.sv
// Identifier match and fixed-point decode of one received frame.
`default_nettype none

module cvsd_decode (
    input  wire cvsd_pkg::t_cfg       i_cfg,
    input  wire logic [28:0]          i_identifier,
    input  wire logic [3:0]           i_length,
    input  wire logic [7:0]           i_byte0,
    input  wire logic [7:0]           i_byte1,
    input  wire logic [7:0]           i_byte2,
    input  wire logic [7:0]           i_byte3,
    output cvsd_pkg::t_decoded        o_dec
);

    logic [15:0]        w01;
    logic [15:0]        w23;
    logic               hit;
    cvsd_pkg::t_reg_idx sel;
    logic [21:0]        wa_num;
    logic [21:0]        wb_num;
    logic [45:0]        wa_prod;
    logic [45:0]        wb_prod;
    logic [16:0]        steer_mag;
    logic [23:0]        steer_num;
    logic [46:0]        steer_prod;
    logic [23:0]        steer_val;
    logic [8:0]         temp_a;
    logic [8:0]         temp_b;
    logic               len_ge1;
    logic               len_ge2;
    logic               len_ge4;

    assign w01 = {i_byte0, i_byte1};
    assign w23 = {i_byte2, i_byte3};

    assign len_ge1 = (i_length >= 4'd1);
    assign len_ge2 = (i_length >= 4'd2);
    assign len_ge4 = (i_length >= 4'd4);

    // Lowest register index wins when several identifiers are equal.
    always_comb begin
        hit = 1'b0;
        sel = cvsd_pkg::REG_RPM_ID;
        for (int i = cvsd_pkg::NumIds - 1; i >= 0; i--) begin
            if (i_cfg.ids[i] == i_identifier) begin
                hit = 1'b1;
                sel = cvsd_pkg::t_reg_idx'(3'(i));
            end
        end
    end

    // Wheel speed: round(w * 256 / 100) equals floor((w * 64 + 12) / 25).
    assign wa_num  = {w01, 6'd0} + 22'd12;
    assign wb_num  = {w23, 6'd0} + 22'd12;
    assign wa_prod = 46'(wa_num) * 46'(cvsd_pkg::WheelRecip);
    assign wb_prod = 46'(wb_num) * 46'(cvsd_pkg::WheelRecip);

    // Steering: round(|w| * 128 / 5) on the magnitude, sign applied afterward.
    assign steer_mag  = w01[15] ? (17'h10000 - {1'b0, w01}) : {1'b0, w01};
    assign steer_num  = {steer_mag, 7'd0} + 24'd2;
    assign steer_prod = 47'(steer_num) * 47'(cvsd_pkg::SteerRecip);
    assign steer_val  = w01[15] ? (24'd0 - {2'd0, steer_prod[46:cvsd_pkg::SteerShift]})
                                : {2'd0, steer_prod[46:cvsd_pkg::SteerShift]};

    assign temp_a = {1'b0, i_byte0} - 9'd40;
    assign temp_b = {1'b0, i_byte1} - 9'd40;

    always_comb begin
        o_dec.kind    = cvsd_pkg::KIND_NONE;
        o_dec.value_a = '0;
        o_dec.value_b = '0;
        if (hit) begin
            unique case (sel)
                cvsd_pkg::REG_RPM_ID: begin
                    if (len_ge2) begin
                        o_dec.kind    = cvsd_pkg::KIND_RPM;
                        o_dec.value_a = {2'd0, w01, 6'd0};
                    end
                end
                cvsd_pkg::REG_THROTTLE_ID: begin
                    if (len_ge2) begin
                        o_dec.kind    = cvsd_pkg::KIND_THROTTLE;
                        o_dec.value_a = {8'd0, w01} * 24'd25;
                    end
                end
                cvsd_pkg::REG_TEMP_ID: begin
                    if (len_ge2) begin
                        o_dec.kind    = cvsd_pkg::KIND_TEMPS;
                        o_dec.value_a = {{7{temp_a[8]}}, temp_a, 8'd0};
                        o_dec.value_b = {{7{temp_b[8]}}, temp_b, 8'd0};
                    end
                end
                cvsd_pkg::REG_FRONT_ID, cvsd_pkg::REG_REAR_ID: begin
                    if (len_ge4) begin
                        o_dec.kind    = (sel == cvsd_pkg::REG_FRONT_ID) ?
                                        cvsd_pkg::KIND_FRONT : cvsd_pkg::KIND_REAR;
                        o_dec.value_a = {6'd0, wa_prod[45:cvsd_pkg::WheelShift]};
                        o_dec.value_b = {6'd0, wb_prod[45:cvsd_pkg::WheelShift]};
                    end
                end
                cvsd_pkg::REG_STEERING_ID: begin
                    if (len_ge2) begin
                        o_dec.kind    = cvsd_pkg::KIND_STEERING;
                        o_dec.value_a = steer_val;
                    end
                end
                cvsd_pkg::REG_BRAKE_ID: begin
                    if (len_ge1) begin
                        o_dec.kind    = cvsd_pkg::KIND_BRAKE;
                        o_dec.value_a = i_byte0[0] ? 24'sd256 : 24'sd0;
                    end
                end
                default: begin
                    o_dec.kind = cvsd_pkg::KIND_NONE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hdl/can_vehicle_signal_decoder.sv
// Top level of the CAN vehicle signal decoder: input stage, bus state and result stage.
//
// Usage: received frames and time ticks enter on the input channel
// (i_in_valid / o_in_ready, operation 0 for a frame, 1 for a tick). Every
// item yields exactly one result on the output channel (o_out_valid /
// i_out_ready) carrying the decoded kind, two signed Q8 values, the
// saturating frame count and the link-up flag after that item.
// An item that is taken sits in the input register, is decoded by the
// identifier match and constant-reciprocal scaling logic, and lands in
// the result register when the result register can advance.
// Throughput is one item per cycle; the result register and input register
// advance together, so a new item is taken while a result is being taken.
// When the receiver stalls, the result register holds and the input
// register fills; o_in_ready then drops until the result drains.
// Reset clears both stages, the frame count, last frame time and the
// active flag, sets identifiers to zero and the timeout to 500000 us.
// The user writes configuration registers through the APB-style port only
// while no item is in flight; the block itself does not enforce this.
`default_nettype none

module can_vehicle_signal_decoder (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_operation,
    input  wire logic [28:0]          i_identifier,
    input  wire logic [3:0]           i_length,
    input  wire logic [7:0]           i_byte0,
    input  wire logic [7:0]           i_byte1,
    input  wire logic [7:0]           i_byte2,
    input  wire logic [7:0]           i_byte3,
    input  wire logic [63:0]          i_time_us,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [3:0]                o_kind,
    output logic signed [23:0]        o_value_a,
    output logic signed [23:0]        o_value_b,
    output logic [31:0]               o_frames_seen,
    output logic                      o_link_up,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [4:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    cvsd_pkg::t_cfg     cfg;
    cvsd_pkg::t_decoded dec;

    logic               r_in_valid;
    logic               r_op;
    logic [28:0]        r_identifier;
    logic [3:0]         r_length;
    logic [7:0]         r_byte0;
    logic [7:0]         r_byte1;
    logic [7:0]         r_byte2;
    logic [7:0]         r_byte3;
    logic [63:0]        r_time;

    logic [31:0]        r_frame_count;
    logic [31:0]        n_frame_count;
    logic [63:0]        r_last_time;
    logic [63:0]        n_last_time;
    logic               r_active;
    logic               n_active;
    logic [63:0]        elapsed;

    logic               r_out_valid;
    cvsd_pkg::t_kind    r_kind;
    logic signed [23:0] r_value_a;
    logic signed [23:0] r_value_b;
    logic [31:0]        r_frames;
    logic               r_link_up;

    cvsd_pkg::t_kind    n_kind;
    logic signed [23:0] n_value_a;
    logic signed [23:0] n_value_b;

    logic               advance;
    logic               step;

    cvsd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cvsd_decode u_decode (
        .i_cfg        (cfg),
        .i_identifier (r_identifier),
        .i_length     (r_length),
        .i_byte0      (r_byte0),
        .i_byte1      (r_byte1),
        .i_byte2      (r_byte2),
        .i_byte3      (r_byte3),
        .o_dec        (dec)
    );

    // The result register can take a new result when empty or being drained.
    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || advance;
    assign step       = r_in_valid && advance;

    assign elapsed = r_time - r_last_time;

    always_comb begin
        n_frame_count = r_frame_count;
        n_last_time   = r_last_time;
        n_active      = r_active;
        n_kind        = dec.kind;
        n_value_a     = dec.value_a;
        n_value_b     = dec.value_b;
        if (r_op) begin
            if (elapsed > {32'd0, cfg.timeout_us}) begin
                n_active = 1'b0;
            end
            n_kind    = cvsd_pkg::KIND_TICK;
            n_value_a = '0;
            n_value_b = '0;
        end else begin
            if (r_frame_count != 32'hFFFF_FFFF) begin
                n_frame_count = r_frame_count + 32'd1;
            end
            n_last_time = r_time;
            n_active    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_op         <= i_operation;
            r_identifier <= i_identifier;
            r_length     <= i_length;
            r_byte0      <= i_byte0;
            r_byte1      <= i_byte1;
            r_byte2      <= i_byte2;
            r_byte3      <= i_byte3;
            r_time       <= i_time_us;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= '0;
            r_last_time   <= '0;
            r_active      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (step) begin
                r_frame_count <= n_frame_count;
                r_last_time   <= n_last_time;
                r_active      <= n_active;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_kind    <= n_kind;
            r_value_a <= n_value_a;
            r_value_b <= n_value_b;
            r_frames  <= n_frame_count;
            r_link_up <= n_active;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_value_a     = r_value_a;
    assign o_value_b     = r_value_b;
    assign o_frames_seen = r_frames;
    assign o_link_up     = r_link_up;

endmodule

`default_nettype wire
